// ===== hdl/rrps_pkg.sv =====
// Shared types, codes and defaults of the round-robin process scheduler.
package rrps_pkg;

  localparam int MAX_PROCESSES_DEF = 16;
  localparam int COUNTER_WIDTH_DEF = 32;
  localparam int REM_W             = 16;
  localparam int PID_PORT_W        = 5;
  localparam int METRIC_W          = 32;
  localparam logic [7:0] QUANTUM_RESET = 8'd4;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_KILL   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PS_UNUSED     = 2'd0,
    PS_READY      = 2'd1,
    PS_RUNNING    = 2'd2,
    PS_TERMINATED = 2'd3
  } proc_state_t;

  typedef enum logic {
    ALU_INC_SAT   = 1'b0,
    ALU_DEC_FLOOR = 1'b1
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_CHECK,
    S_RUN_RD,
    S_RUN_REM,
    S_RUN_TURN,
    S_SWEEP,
    S_FINAL,
    S_RPT_RD,
    S_RPT
  } sched_state_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

endpackage

// ===== hdl/rrps_alu.sv =====
// Shared counter unit: saturating increment and floor-at-zero decrement.
module rrps_alu #(
  parameter int COUNTER_WIDTH = rrps_pkg::COUNTER_WIDTH_DEF,
  parameter int AW            = rrps_pkg::COUNTER_WIDTH_DEF
) (
  input  rrps_pkg::alu_op_t op,
  input  logic [AW-1:0]     a,
  output logic [AW-1:0]     y
);
  import rrps_pkg::*;

  localparam logic [AW-1:0] CMAX = AW'({COUNTER_WIDTH{1'b1}});

  always_comb begin
    unique case (op)
      ALU_INC_SAT:   y = (a >= CMAX) ? CMAX : a + AW'(1);
      ALU_DEC_FLOOR: y = (a == '0) ? '0 : a - AW'(1);
      default:       y = a;
    endcase
  end

endmodule

// ===== hdl/rrps_fifo.sv =====
// Ready queue: circular buffer of process ids with registered head read.
module rrps_fifo #(
  parameter int DEPTH = rrps_pkg::MAX_PROCESSES_DEF,
  parameter int PID_W = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rrps_pkg::fifo_ctrl_t ctrl,
  input  logic [PID_W-1:0]     push_pid,
  output logic [PID_W-1:0]     head_pid,
  output logic                 nonempty
);
  import rrps_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [PID_W-1:0] mem [0:DEPTH-1];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  // drop a push into a full queue
  assign do_push  = ctrl.push && (count != CNT_W'(DEPTH));
  assign do_pop   = ctrl.pop && (count != '0);
  assign nonempty = (count != '0);

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= push_pid;
    end
    head_pid <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + PTR_W'(1);
      end
      if (do_pop) begin
        head <= (head == PTR_W'(DEPTH - 1)) ? '0 : head + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/round_robin_process_scheduler_unit.sv =====
// Round-robin process scheduler: sequencer, process table and metric memories.
// A tick sweeps the table one entry a cycle through the one shared counter unit.
// One command at a time: busy stays high until done.
// Reset (rst, synchronous) clears control state and marks every entry unused;
// the done strobe is shown for one cycle and cannot be held off.
module round_robin_process_scheduler_unit #(
  parameter int MAX_PROCESSES = rrps_pkg::MAX_PROCESSES_DEF,
  parameter int COUNTER_WIDTH = rrps_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      command,
  input  logic [rrps_pkg::REM_W-1:0]      burst_length,
  input  logic [rrps_pkg::PID_PORT_W-1:0] target_pid,
  output logic                            done,
  output logic [rrps_pkg::PID_PORT_W-1:0] result_pid,
  output logic [1:0]                      process_state,
  output logic                            error_flag,
  output logic                            finished_flag,
  output logic                            preempted_flag,
  output logic [rrps_pkg::METRIC_W-1:0]   waiting_ticks,
  output logic [rrps_pkg::METRIC_W-1:0]   turnaround_ticks,
  output logic [rrps_pkg::REM_W-1:0]      remaining_ticks,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [7:0]                      cfg_data
);
  import rrps_pkg::*;

  localparam int PID_W = $clog2(MAX_PROCESSES + 1);
  localparam int NP_W  = $clog2(MAX_PROCESSES + 2);
  localparam int AW    = (COUNTER_WIDTH > REM_W) ? COUNTER_WIDTH : REM_W;
  localparam logic [NP_W-1:0] PID_MAX  = NP_W'(MAX_PROCESSES);
  localparam logic [NP_W-1:0] SWEEP_END = NP_W'(MAX_PROCESSES + 1);

  // Clip a counter to the 32-bit metric ports.
  function automatic logic [METRIC_W-1:0] clip_metric(input logic [COUNTER_WIDTH-1:0] v);
    logic [2*METRIC_W-1:0] w;
    w = (2*METRIC_W)'(v);
    return (|w[2*METRIC_W-1:METRIC_W]) ? '1 : w[METRIC_W-1:0];
  endfunction

  // Control state
  sched_state_t       state, state_next;
  cmd_t               cmd_q;
  logic [REM_W-1:0]   burst_q;
  logic [PID_PORT_W-1:0] target_q;
  logic [PID_W-1:0]   running_pid, running_next;
  logic [7:0]         slice_counter, slice_next;
  logic [NP_W-1:0]    next_pid, next_pid_next;
  logic [NP_W-1:0]    idx, idx_next;
  logic [PID_W-1:0]   rpt_pid, rpt_pid_next;
  logic               fin_q, fin_next;
  logic               pre_q, pre_next;
  logic [REM_W-1:0]   cur_rem, cur_rem_next;
  logic [7:0]         quantum_ticks;

  // Process table: state in flops, metrics in memories
  proc_state_t        entry_state [0:MAX_PROCESSES];
  logic [REM_W-1:0]   rem_mem  [0:MAX_PROCESSES];
  logic [COUNTER_WIDTH-1:0] wait_mem [0:MAX_PROCESSES];
  logic [COUNTER_WIDTH-1:0] turn_mem [0:MAX_PROCESSES];
  logic [REM_W-1:0]   rem_q;
  logic [COUNTER_WIDTH-1:0] wait_q;
  logic [COUNTER_WIDTH-1:0] turn_q;

  // Table access controls
  logic [PID_W-1:0]   st_addr;
  proc_state_t        st_rd;
  logic               st_we;
  logic [PID_W-1:0]   st_waddr;
  proc_state_t        st_wdata;
  logic [PID_W-1:0]   mem_raddr;
  logic [PID_W-1:0]   mem_waddr;
  logic               rem_we, wait_we, turn_we;
  logic [REM_W-1:0]   rem_wdata;
  logic [COUNTER_WIDTH-1:0] wait_wdata, turn_wdata;

  // Shared unit and queue
  alu_op_t            alu_op;
  logic [AW-1:0]      alu_a, alu_y;
  fifo_ctrl_t         fifo_ctrl;
  logic [PID_W-1:0]   fifo_push_pid;
  logic [PID_W-1:0]   fifo_head_pid;
  logic               fifo_nonempty;

  // Result load
  logic               out_load;
  logic [PID_PORT_W-1:0] o_pid;
  proc_state_t        o_state;
  logic               o_err, o_fin, o_pre;
  logic [METRIC_W-1:0] o_wait, o_turn;
  logic [REM_W-1:0]   o_rem;

  logic               accept;
  logic               tgt_ok;
  logic [PID_W-1:0]   tgt_pid;
  logic [NP_W-1:0]    idx_m1;
  logic [PID_W-1:0]   wb_addr;
  logic [7:0]         slice_inc;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign tgt_ok  = (target_q != '0) && (int'(target_q) <= MAX_PROCESSES);
  assign tgt_pid = PID_W'(target_q);
  assign idx_m1  = idx - NP_W'(1);
  assign wb_addr = PID_W'(idx_m1);
  assign slice_inc = (slice_counter < 8'hFF) ? slice_counter + 8'd1 : slice_counter;
  assign st_rd   = entry_state[st_addr];

  rrps_alu #(
    .COUNTER_WIDTH (COUNTER_WIDTH),
    .AW            (AW)
  ) u_alu (
    .op (alu_op),
    .a  (alu_a),
    .y  (alu_y)
  );

  rrps_fifo #(
    .DEPTH (MAX_PROCESSES),
    .PID_W (PID_W)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (fifo_ctrl),
    .push_pid (fifo_push_pid),
    .head_pid (fifo_head_pid),
    .nonempty (fifo_nonempty)
  );

  // Sequencer: next state, table controls and result load
  always_comb begin
    state_next    = state;
    running_next  = running_pid;
    slice_next    = slice_counter;
    next_pid_next = next_pid;
    idx_next      = idx;
    rpt_pid_next  = rpt_pid;
    fin_next      = fin_q;
    pre_next      = pre_q;
    cur_rem_next  = cur_rem;

    st_addr   = rpt_pid;
    st_we     = 1'b0;
    st_waddr  = rpt_pid;
    st_wdata  = PS_READY;
    mem_raddr = running_pid;
    mem_waddr = running_pid;
    rem_we    = 1'b0;
    wait_we   = 1'b0;
    turn_we   = 1'b0;
    rem_wdata  = burst_q;
    wait_wdata = '0;
    turn_wdata = '0;

    alu_op = ALU_INC_SAT;
    alu_a  = '0;
    fifo_ctrl     = '0;
    fifo_push_pid = running_pid;

    out_load = 1'b0;
    o_pid    = '0;
    o_state  = PS_UNUSED;
    o_err    = 1'b0;
    o_fin    = 1'b0;
    o_pre    = 1'b0;
    o_wait   = '0;
    o_turn   = '0;
    o_rem    = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        fin_next = 1'b0;
        pre_next = 1'b0;
        unique case (cmd_q)
          CMD_CREATE: begin
            if (next_pid > PID_MAX) begin
              // table full: error with every other field zero
              out_load   = 1'b1;
              o_err      = 1'b1;
              state_next = S_IDLE;
            end else begin
              st_we         = 1'b1;
              st_waddr      = PID_W'(next_pid);
              st_wdata      = PS_READY;
              mem_waddr     = PID_W'(next_pid);
              rem_we        = 1'b1;
              wait_we       = 1'b1;
              turn_we       = 1'b1;
              fifo_ctrl.push = 1'b1;
              fifo_push_pid = PID_W'(next_pid);
              next_pid_next = next_pid + NP_W'(1);
              rpt_pid_next  = PID_W'(next_pid);
              state_next    = S_RPT_RD;
            end
          end
          CMD_TICK: begin
            if (running_pid != '0) begin
              state_next = S_RUN_RD;
            end else if (fifo_nonempty) begin
              state_next = S_POP;
            end else begin
              // idle tick: nothing to run
              out_load   = 1'b1;
              state_next = S_IDLE;
            end
          end
          CMD_KILL, CMD_READ: begin
            st_addr = tgt_ok ? tgt_pid : '0;
            if (!tgt_ok || st_rd == PS_UNUSED) begin
              out_load   = 1'b1;
              o_pid      = target_q;
              o_err      = 1'b1;
              state_next = S_IDLE;
            end else begin
              if (cmd_q == CMD_KILL) begin
                st_we    = 1'b1;
                st_waddr = tgt_pid;
                st_wdata = PS_TERMINATED;
                if (running_pid == tgt_pid) begin
                  running_next = '0;
                  slice_next   = '0;
                end
              end
              rpt_pid_next = tgt_pid;
              state_next   = S_RPT_RD;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end

      S_POP: begin
        fifo_ctrl.pop = 1'b1;
        state_next    = S_CHECK;
      end

      S_CHECK: begin
        // skip queue entries that were killed while waiting
        st_addr = fifo_head_pid;
        if (st_rd == PS_READY) begin
          st_we        = 1'b1;
          st_waddr     = fifo_head_pid;
          st_wdata     = PS_RUNNING;
          running_next = fifo_head_pid;
          slice_next   = '0;
          state_next   = S_RUN_RD;
        end else if (fifo_nonempty) begin
          state_next = S_POP;
        end else begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_RUN_RD: begin
        state_next = S_RUN_REM;
      end

      S_RUN_REM: begin
        alu_op       = ALU_DEC_FLOOR;
        alu_a        = AW'(rem_q);
        rem_we       = 1'b1;
        rem_wdata    = REM_W'(alu_y);
        cur_rem_next = REM_W'(alu_y);
        state_next   = S_RUN_TURN;
      end

      S_RUN_TURN: begin
        alu_op     = ALU_INC_SAT;
        alu_a      = AW'(turn_q);
        turn_we    = 1'b1;
        turn_wdata = COUNTER_WIDTH'(alu_y);
        slice_next = slice_inc;
        idx_next   = NP_W'(1);
        state_next = S_SWEEP;
      end

      S_SWEEP: begin
        // read entry idx, write back entry idx-1
        mem_raddr = (idx <= PID_MAX) ? PID_W'(idx) : '0;
        mem_waddr = wb_addr;
        st_addr   = wb_addr;
        if (idx >= NP_W'(2) && wb_addr != running_pid && st_rd == PS_READY) begin
          alu_op     = ALU_INC_SAT;
          alu_a      = AW'(wait_q);
          wait_we    = 1'b1;
          wait_wdata = COUNTER_WIDTH'(alu_y);
        end
        idx_next = idx + NP_W'(1);
        if (idx == SWEEP_END) begin
          state_next = S_FINAL;
        end
      end

      S_FINAL: begin
        rpt_pid_next = running_pid;
        st_waddr     = running_pid;
        if (cur_rem == '0) begin
          fin_next     = 1'b1;
          st_we        = 1'b1;
          st_wdata     = PS_TERMINATED;
          running_next = '0;
        end else if (slice_counter >= quantum_ticks) begin
          pre_next       = 1'b1;
          st_we          = 1'b1;
          st_wdata       = PS_READY;
          fifo_ctrl.push = 1'b1;
          fifo_push_pid  = running_pid;
          running_next   = '0;
        end
        state_next = S_RPT_RD;
      end

      S_RPT_RD: begin
        mem_raddr  = rpt_pid;
        state_next = S_RPT;
      end

      S_RPT: begin
        st_addr    = rpt_pid;
        out_load   = 1'b1;
        o_pid      = PID_PORT_W'(rpt_pid);
        o_state    = st_rd;
        o_fin      = fin_q;
        o_pre      = pre_q;
        o_wait     = clip_metric(wait_q);
        o_turn     = clip_metric(turn_q);
        o_rem      = rem_q;
        state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  // State register and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running_pid   <= '0;
      slice_counter <= '0;
      next_pid      <= NP_W'(1);
      idx           <= '0;
      rpt_pid       <= '0;
      fin_q         <= 1'b0;
      pre_q         <= 1'b0;
      done          <= 1'b0;
    end else begin
      state         <= state_next;
      running_pid   <= running_next;
      slice_counter <= slice_next;
      next_pid      <= next_pid_next;
      idx           <= idx_next;
      rpt_pid       <= rpt_pid_next;
      fin_q         <= fin_next;
      pre_q         <= pre_next;
      done          <= out_load;
    end
  end

  // Quantum register: written through its own channel, always ready
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum_ticks <= QUANTUM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      quantum_ticks <= cfg_data;
    end
  end

  // Capture the command transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= cmd_t'(command);
      burst_q  <= burst_length;
      target_q <= target_pid;
    end
    cur_rem <= cur_rem_next;
  end

  // Entry states: flops cleared to unused by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= MAX_PROCESSES; i++) begin
        entry_state[i] <= PS_UNUSED;
      end
    end else if (st_we) begin
      entry_state[st_waddr] <= st_wdata;
    end
  end

  // Metric memories: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[mem_waddr] <= rem_wdata;
    end
    if (wait_we) begin
      wait_mem[mem_waddr] <= wait_wdata;
    end
    if (turn_we) begin
      turn_mem[mem_waddr] <= turn_wdata;
    end
    rem_q  <= rem_mem[mem_raddr];
    wait_q <= wait_mem[mem_raddr];
    turn_q <= turn_mem[mem_raddr];
  end

  // Result registers, loaded together with done and held until the next result
  always_ff @(posedge clk) begin
    if (out_load) begin
      result_pid       <= o_pid;
      process_state    <= o_state;
      error_flag       <= o_err;
      finished_flag    <= o_fin;
      preempted_flag   <= o_pre;
      waiting_ticks    <= o_wait;
      turnaround_ticks <= o_turn;
      remaining_ticks  <= o_rem;
    end
  end

endmodule

// ===== hdl/rrps_checker.sv =====
// Port-level checks of the scheduler and the bind that attaches them.
module rrps_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            done,
  input logic [rrps_pkg::PID_PORT_W-1:0] result_pid,
  input logic [1:0]                      process_state,
  input logic                            error_flag,
  input logic                            finished_flag,
  input logic                            preempted_flag
);
  import rrps_pkg::*;

  // a result is shown only once the command is complete
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // an accepted command never completes in its first cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("command not held busy after accept");

  // an error result carries no process state or tick flags
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (done && error_flag) |->
      (process_state == PS_UNUSED && !finished_flag && !preempted_flag))
    else $error("error result with state or flags");

  // a finished process is reported terminated
  a_finish_state: assert property (@(posedge clk) disable iff (rst)
    (done && finished_flag) |->
      (process_state == PS_TERMINATED && !preempted_flag && result_pid != '0))
    else $error("finished result inconsistent");

  // a preempted process is reported back in the ready queue
  a_preempt_state: assert property (@(posedge clk) disable iff (rst)
    (done && preempted_flag) |-> (process_state == PS_READY && result_pid != '0))
    else $error("preempted result inconsistent");

endmodule

bind round_robin_process_scheduler_unit rrps_checker u_rrps_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .result_pid     (result_pid),
  .process_state  (process_state),
  .error_flag     (error_flag),
  .finished_flag  (finished_flag),
  .preempted_flag (preempted_flag)
);

// ===== tb/round_robin_process_scheduler_unit_tb.sv =====
// Self-checking testbench for the round-robin process scheduler unit.
`timescale 1ns / 100ps

module round_robin_process_scheduler_unit_tb;
  import rrps_pkg::*;

  localparam int MAXP = MAX_PROCESSES_DEF;

  // One result transaction, laid out in port order so the ports pack straight in.
  typedef struct packed {
    logic [PID_PORT_W-1:0] pid;
    logic [1:0]            pstate;
    logic                  err;
    logic                  fin;
    logic                  pre;
    logic [METRIC_W-1:0]   waited;
    logic [METRIC_W-1:0]   turned;
    logic [REM_W-1:0]      rem;
  } sched_outcome_t;

  // Process table, ready ring and core state, advanced once per accepted command.
  class sched_scoreboard;
    logic [7:0]            quantum;
    logic [PID_PORT_W-1:0] ready_ring [MAXP];
    int unsigned           head, tail, count;
    int unsigned           running;
    logic [7:0]            slice;
    int unsigned           next_id;
    logic [1:0]            state_of [1:MAXP];
    logic [REM_W-1:0]      rem_of   [1:MAXP];
    logic [METRIC_W-1:0]   wait_of  [1:MAXP];
    logic [METRIC_W-1:0]   turn_of  [1:MAXP];
    sched_outcome_t        pending_outcomes [$];
    int unsigned           mismatches;

    function new();
      quantum = QUANTUM_RESET;
      head = 0;
      tail = 0;
      count = 0;
      running = 0;
      slice = '0;
      next_id = 1;
      mismatches = 0;
      for (int i = 1; i <= MAXP; i++) begin
        state_of[i] = PS_UNUSED;
        rem_of[i] = '0;
        wait_of[i] = '0;
        turn_of[i] = '0;
      end
    endfunction

    function logic [METRIC_W-1:0] sat_up(logic [METRIC_W-1:0] v);
      return (v == {METRIC_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    function void enqueue(int unsigned p);
      if (count >= MAXP) return;
      ready_ring[tail] = p[PID_PORT_W-1:0];
      tail = (tail + 1) % MAXP;
      count++;
    endfunction

    function sched_outcome_t outcome_of(int unsigned p);
      sched_outcome_t o;
      o = '0;
      o.pid = p[PID_PORT_W-1:0];
      o.pstate = state_of[p];
      o.waited = wait_of[p];
      o.turned = turn_of[p];
      o.rem = rem_of[p];
      return o;
    endfunction

    // Advance the table for one accepted command and queue the result it must give.
    function void note_command(cmd_t c, logic [REM_W-1:0] b, logic [PID_PORT_W-1:0] t);
      sched_outcome_t o;
      int unsigned p, cur;
      logic fin, pre;
      o = '0;
      fin = 1'b0;
      pre = 1'b0;
      case (c)
        CMD_CREATE: begin
          if (next_id > MAXP) begin
            o.err = 1'b1;
          end else begin
            p = next_id;
            next_id++;
            state_of[p] = PS_READY;
            rem_of[p] = b;
            wait_of[p] = '0;
            turn_of[p] = '0;
            enqueue(p);
            o = outcome_of(p);
          end
        end
        CMD_TICK: begin
          // Pop until a still-ready entry shows up; killed entries fall out here.
          while (running == 0 && count > 0) begin
            p = ready_ring[head];
            head = (head + 1) % MAXP;
            count--;
            if (p >= 1 && p <= MAXP && state_of[p] == PS_READY) begin
              running = p;
              state_of[p] = PS_RUNNING;
              slice = '0;
            end
          end
          if (running != 0) begin
            cur = running;
            if (rem_of[cur] != 0) rem_of[cur] = rem_of[cur] - 1'b1;
            for (int i = 1; i <= MAXP; i++)
              if (i != cur && state_of[i] == PS_READY) wait_of[i] = sat_up(wait_of[i]);
            turn_of[cur] = sat_up(turn_of[cur]);
            if (slice != 8'hFF) slice = slice + 1'b1;
            if (rem_of[cur] == 0) begin
              fin = 1'b1;
              state_of[cur] = PS_TERMINATED;
              running = 0;
            end else if (slice >= quantum) begin
              pre = 1'b1;
              state_of[cur] = PS_READY;
              enqueue(cur);
              running = 0;
            end
            o = outcome_of(cur);
            o.fin = fin;
            o.pre = pre;
          end
        end
        default: begin
          if (!(t >= 1 && t <= MAXP && state_of[t] != PS_UNUSED)) begin
            o.pid = t;
            o.err = 1'b1;
          end else begin
            if (c == CMD_KILL) begin
              state_of[t] = PS_TERMINATED;
              if (running == t) begin
                running = 0;
                slice = '0;
              end
            end
            o = outcome_of(t);
          end
        end
      endcase
      pending_outcomes.push_back(o);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task field_check(string name, logic [METRIC_W-1:0] got, logic [METRIC_W-1:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_outcome(sched_outcome_t got);
      sched_outcome_t want;
      if (pending_outcomes.size() == 0) begin
        report_mismatch($sformatf("result with none expected, pid %0d", got.pid));
        return;
      end
      want = pending_outcomes.pop_front();
      field_check("result_pid", got.pid, want.pid);
      field_check("process_state", got.pstate, want.pstate);
      field_check("error_flag", got.err, want.err);
      field_check("finished_flag", got.fin, want.fin);
      field_check("preempted_flag", got.pre, want.pre);
      field_check("waiting_ticks", got.waited, want.waited);
      field_check("turnaround_ticks", got.turned, want.turned);
      field_check("remaining_ticks", got.rem, want.rem);
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            command = CMD_CREATE;
  logic [REM_W-1:0]      burst_length = '0;
  logic [PID_PORT_W-1:0] target_pid = '0;
  logic                  done;
  logic [PID_PORT_W-1:0] result_pid;
  logic [1:0]            process_state;
  logic                  error_flag;
  logic                  finished_flag;
  logic                  preempted_flag;
  logic [METRIC_W-1:0]   waiting_ticks;
  logic [METRIC_W-1:0]   turnaround_ticks;
  logic [REM_W-1:0]      remaining_ticks;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [7:0]            cfg_data = '0;

  sched_scoreboard sched_sb = new();

  round_robin_process_scheduler_unit u_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .command          (command),
    .burst_length     (burst_length),
    .target_pid       (target_pid),
    .done             (done),
    .result_pid       (result_pid),
    .process_state    (process_state),
    .error_flag       (error_flag),
    .finished_flag    (finished_flag),
    .preempted_flag   (preempted_flag),
    .waiting_ticks    (waiting_ticks),
    .turnaround_ticks (turnaround_ticks),
    .remaining_ticks  (remaining_ticks),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always #1 clk = ~clk;

  // Check every done strobe against the oldest expected transaction; results
  // cannot be held off, so sample each one at the edge that ends its cycle.
  always @(posedge clk) begin
    sched_outcome_t got;
    if (!rst && done === 1'b1) begin
      got = {result_pid, process_state, error_flag, finished_flag, preempted_flag,
             waiting_ticks, turnaround_ticks, remaining_ticks};
      sched_sb.check_outcome(got);
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Short bursts keep processes finishing; a few zero and full-range ones mixed in.
  function automatic logic [REM_W-1:0] pick_burst();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 15) return REM_W'($urandom_range(0, 65535));
    return REM_W'($urandom_range(1, 30));
  endfunction

  // Hold start high until the block takes the transaction, then note it.
  // Start is left high so a back-to-back command needs no second assignment.
  task automatic issue(cmd_t c, logic [REM_W-1:0] b, logic [PID_PORT_W-1:0] t);
    start <= 1'b1;
    command <= c;
    burst_length <= b;
    target_pid <= t;
    do @(posedge clk); while (busy !== 1'b0);
    sched_sb.note_command(c, b, t);
  endtask

  // Issue one command and idle the sender for a random gap.
  task automatic step(cmd_t c, logic [REM_W-1:0] b, logic [PID_PORT_W-1:0] t);
    int unsigned n;
    issue(c, b, t);
    n = pick_gap();
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drop start and wait, at least one edge, until every expected result has arrived.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sched_sb.pending_outcomes.size() != 0 || busy !== 1'b0);
  endtask

  // Every command gives a result, so an empty expectation queue means idle.
  task automatic write_quantum(logic [7:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sched_sb.quantum = v;
    cfg_valid <= 1'b0;
  endtask

  // Mostly ticks, with creates, kills and reads aimed at handed-out ids.
  task automatic rand_item();
    int unsigned r, live;
    logic [PID_PORT_W-1:0] t;
    r = $urandom_range(0, 99);
    live = sched_sb.next_id - 1;
    if (live > 0 && $urandom_range(0, 4) != 0) t = PID_PORT_W'($urandom_range(1, live));
    else t = PID_PORT_W'($urandom_range(0, 31));
    if (r < 3) step(CMD_CREATE, pick_burst(), t);
    else if (r < 7) step(CMD_KILL, pick_burst(), t);
    else if (r < 19) step(CMD_READ, pick_burst(), t);
    else step(CMD_TICK, pick_burst(), t);
  endtask

  initial begin
    logic [7:0] q;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part, at the reset quantum of four.
    step(CMD_TICK, 16'd0, 5'd0);          // idle tick: nothing ready
    step(CMD_READ, 16'd0, 5'd0);          // id zero is never valid
    step(CMD_KILL, 16'hFFFF, 5'd31);      // id above the table
    step(CMD_READ, 16'd0, 5'd5);          // unused entry
    step(CMD_CREATE, 16'd0, 5'd0);        // zero burst: retires on first run
    step(CMD_CREATE, 16'hFFFF, 5'd31);    // full burst
    step(CMD_CREATE, 16'd3, 5'd0);
    step(CMD_TICK, 16'd0, 5'd0);          // pid 1 finishes at once
    repeat (4) step(CMD_TICK, 16'd0, 5'd0); // pid 2 uses its quantum
    step(CMD_TICK, 16'd0, 5'd0);          // pid 3 runs
    step(CMD_KILL, 16'd0, 5'd3);          // kill the running process
    step(CMD_TICK, 16'd0, 5'd0);          // core idle again, pid 2 dispatched
    step(CMD_KILL, 16'd0, 5'd1);          // kill of a terminated process
    step(CMD_READ, 16'd0, 5'd2);
    step(CMD_READ, 16'd0, 5'd1);
    step(CMD_CREATE, 16'd1, 5'd0);
    step(CMD_KILL, 16'd0, 5'd4);          // killed while queued
    repeat (4) step(CMD_TICK, 16'd0, 5'd0); // dispatch skips the killed entry
    step(CMD_READ, 16'd0, 5'd16);

    // Random part over several quantum settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: q = 8'd1;
        1: q = 8'd255;
        2: q = 8'd0;
        3: q = 8'd3;
        4: q = 8'($urandom_range(1, 255));
        default: q = 8'd2;
      endcase
      write_quantum(q);
      repeat (105) begin
        // now and then hold the sender until the block has caught up
        if ($urandom_range(0, 39) == 0) drain();
        rand_item();
      end
    end

    drain();
    // let any stray strobe show up before the verdict
    repeat (64) @(posedge clk);
    if (sched_sb.mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
